>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

>>> rtl/ltpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ltpd_pkg;

	localparam int HDR_BYTES = 8;
	localparam int HDR_CNT_W = $clog2(HDR_BYTES);
	localparam logic [HDR_CNT_W-1:0] HDR_LAST_POS = HDR_CNT_W'(HDR_BYTES - 1);

	typedef struct packed {
		logic        valid;
		logic [7:0]  data_byte;
		logic [31:0] msg_kind;
		logic [31:0] msg_length;
		logic        has_data;
		logic        last;
	} ltpd_result_t;

	typedef struct packed {
		logic                 in_payload;
		logic [HDR_CNT_W-1:0] hdr_cnt;
		logic                 left_zero;
	} ltpd_status_t;

endpackage

`default_nettype wire

>>> rtl/ltpd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module ltpd_parser
	import ltpd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         fire,
	input  wire logic [7:0]   in_byte,
	output ltpd_result_t      res,
	output ltpd_status_t      status
);

	logic                 in_payload_q;
	logic [HDR_CNT_W-1:0] hdr_cnt_q;
	logic [31:0]          length_q;
	logic [31:0]          type_q;
	logic [31:0]          left_q;

	logic                 left_le1;
	logic                 hdr_done;
	logic [1:0]           lane;

	assign left_le1 = (left_q[31:1] == 31'd0);
	assign hdr_done = (hdr_cnt_q == HDR_LAST_POS);
	assign lane     = hdr_cnt_q[1:0];

	always_comb begin
		res            = '0;
		res.msg_kind   = type_q;
		res.msg_length = length_q;
		if (in_payload_q) begin
			res.valid     = fire;
			res.data_byte = in_byte;
			res.has_data  = 1'b1;
			res.last      = left_le1;
		end else begin
			// empty message: marker goes out on the final type byte
			res.valid      = fire && hdr_done && (length_q == 32'd0);
			res.msg_kind   = {in_byte, type_q[23:0]};
			res.msg_length = 32'd0;
			res.last       = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			hdr_cnt_q    <= '0;
			length_q     <= '0;
			type_q       <= '0;
			left_q       <= '0;
		end else if (fire) begin
			if (in_payload_q) begin
				if (left_le1) begin
					left_q       <= '0;
					in_payload_q <= 1'b0;
				end else begin
					left_q <= left_q - 32'd1;
				end
			end else begin
				// first byte of each word overwrites, the rest merge in
				if (!hdr_cnt_q[HDR_CNT_W-1]) begin
					if (lane == 2'd0)
						length_q <= {24'd0, in_byte};
					else
						length_q[8*lane +: 8] <= in_byte;
				end else begin
					if (lane == 2'd0)
						type_q <= {24'd0, in_byte};
					else
						type_q[8*lane +: 8] <= in_byte;
				end

				if (hdr_done) begin
					hdr_cnt_q <= '0;
					if (length_q != 32'd0) begin
						left_q       <= length_q;
						in_payload_q <= 1'b1;
					end
				end else begin
					hdr_cnt_q <= hdr_cnt_q + 1'b1;
				end
			end
		end
	end

	assign status.in_payload = in_payload_q;
	assign status.hdr_cnt    = hdr_cnt_q;
	assign status.left_zero  = (left_q == 32'd0);

endmodule

`default_nettype wire

>>> rtl/ltpd_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module ltpd_out_reg
	import ltpd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire ltpd_result_t res,
	output logic              out_free,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [7:0]        data_byte,
	output logic [31:0]       msg_kind,
	output logic [31:0]       msg_length,
	output logic              has_data,
	output logic              last
);

	logic         valid_q;
	logic [7:0]   data_q;
	logic [31:0]  type_q;
	logic [31:0]  length_q;
	logic         has_data_q;
	logic         last_q;

	assign out_free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (out_free)
			valid_q <= res.valid;
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) begin
			data_q     <= res.data_byte;
			type_q     <= res.msg_kind;
			length_q   <= res.msg_length;
			has_data_q <= res.has_data;
			last_q     <= res.last;
		end
	end

	assign out_valid  = valid_q;
	assign data_byte  = data_q;
	assign msg_kind   = type_q;
	assign msg_length = length_q;
	assign has_data   = has_data_q;
	assign last       = last_q;

endmodule

`default_nettype wire

>>> rtl/length_type_prefixed_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Channel   Handshake             Payload
// ------    -------------------   ----------------------------------------------
// input     in_valid / in_stall   in_byte
// output    out_valid / out_stall data_byte, msg_kind, msg_length, has_data, last
//
// One byte is taken every clock while the output is not held off.
// An item crosses an input register and then a result register.
// Header bytes give no item except the empty-message marker on the eighth byte.
// Reset clears the parser to expect a header and empties both registers.
// out_stall reaches in_stall only when the input register is full.

module length_type_prefixed_deframer
	import ltpd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [7:0]   in_byte,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [7:0]        data_byte,
	output logic [31:0]       msg_kind,
	output logic [31:0]       msg_length,
	output logic              has_data,
	output logic              last
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         out_free;
	logic         fire;
	ltpd_result_t res;
	ltpd_status_t status;

	assign in_stall = valid_s1 && !out_free;
	assign fire     = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			byte_s1 <= in_byte;
	end

	ltpd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.in_byte (byte_s1),
		.res     (res),
		.status  (status)
	);

	ltpd_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.res        (res),
		.out_free   (out_free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_byte  (data_byte),
		.msg_kind   (msg_kind),
		.msg_length (msg_length),
		.has_data   (has_data),
		.last       (last)
	);

	// payload phase always has bytes outstanding
	`ASSERT_SAME(a_payload_left, clk, arst_n, status.in_payload, !status.left_zero)
	// header counter sits at zero for the whole payload
	`ASSERT_SAME(a_payload_cnt, clk, arst_n, status.in_payload, status.hdr_cnt == '0)
	// a held input item is not lost or overwritten
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && in_stall, valid_s1 && $stable(byte_s1))

endmodule

`default_nettype wire
